@@ rtl/gzsbf_pkg.sv @@
// Shared constants, codes and helper functions for the gzip stored-block framer.
// No dependencies; used by gzip_stored_block_framer.
package gzsbf_pkg;

    // Input opcodes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Kind of result sequence that one accepted request produces.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [15:0] MAX_CHUNK  = 16'hFFFF;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam int          HEAD_BYTES = 10;
    localparam int          BH_BYTES   = 5;
    localparam int          MAX_RESULTS = 23;

    // Bytewise update of the reflected gzip CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Fixed ten-byte gzip member header: magic, deflate, no flags, no mtime,
    // no extra flags, unknown OS.
    function automatic logic [7:0] head_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h1f;
            4'd1:    b = 8'h8b;
            4'd2:    b = 8'h08;
            4'd9:    b = 8'hff;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/gzip_stored_block_framer.sv @@
// Top level of the gzip stored-block framer: wraps a byte payload as one gzip
// member made of deflate stored blocks. Depends on gzsbf_pkg.
//
// Channel   Direction  Handshake                    Payload
// config    in         i_cfg_wr_en (no wait)        i_cfg_wr_data  (total_length)
// request   in         i_in_valid / o_in_ready      i_op, i_data_byte
// result    out        o_out_valid / i_out_ready    o_out_byte, o_last_of_run,
//                                                   o_member_done, o_error
//
// A request produces 1, 6, 9, 15 or 23 result bytes, one per cycle while
// the result side is ready, and holds the emit stage until its last byte
// is out; payload-byte requests that produce a single result stream at one
// per cycle when not stalled. A request passes the request register, then
// the emit stage, then the result register. The pace is set by the single
// result byte register. Reset is synchronous and active low; it clears all
// control state and sets total_length to zero. A stalled result holds the
// emit stage, which in turn holds the request register; the request side
// keeps accepting until the request register is full.
module gzip_stored_block_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_member_done,
    output logic        o_error
);

    // Configuration and member state.
    logic [31:0] r_total_length;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_bytes_taken, n_bytes_taken;
    logic [15:0] r_chunk_left, n_chunk_left;
    logic        r_active, n_active;

    // Request register.
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;

    // Emit stage: one loaded request's result sequence and its parameters.
    logic        r_job_valid;
    logic [4:0]  r_idx;
    logic [4:0]  r_last_idx, n_last_idx;
    logic [1:0]  r_kind, n_kind;
    logic        r_has_trl, n_has_trl;
    logic        r_bfinal, n_bfinal;
    logic [15:0] r_chunk, n_chunk;
    logic [31:0] r_crc_out, n_crc_out;
    logic [31:0] r_isize;
    logic [7:0]  r_data;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_done;
    logic        r_out_err;

    logic        out_free;
    logic        job_emit;
    logic        job_last;
    logic        load;

    logic [31:0] crc_upd;
    logic [31:0] bt_inc;
    logic [31:0] rem;
    logic [15:0] chunk;
    logic        bfinal;
    logic [15:0] cl_dec;

    logic [4:0]  off_bh_start, off_trl_start, off_data;
    logic [2:0]  bh_sel, trl_sel;
    logic        use_trl;
    logic [7:0]  bh_b, trl_b;
    logic [7:0]  sel_byte;
    logic        sel_done;
    logic        sel_err;

    assign out_free   = !r_out_valid || i_out_ready;
    assign job_emit   = r_job_valid && out_free;
    assign job_last   = (r_idx == r_last_idx);
    assign load       = r_in_valid && (!r_job_valid || (job_emit && job_last));
    assign o_in_ready = !r_in_valid || load;

    // Work out the whole effect of the request in the request register:
    // the next member state and the parameters of the result sequence.
    always_comb begin
        crc_upd = gzsbf_pkg::crc_byte(r_crc, r_in_byte);
        bt_inc  = r_bytes_taken + 32'd1;
        // Bytes left after this payload byte: total - taken - 1.
        rem     = (r_in_op == gzsbf_pkg::OP_START) ? r_total_length
                                                   : r_total_length + ~r_bytes_taken;
        bfinal  = ~|rem[31:16];
        chunk   = bfinal ? rem[15:0] : gzsbf_pkg::MAX_CHUNK;
        cl_dec  = r_chunk_left - {15'd0, (r_chunk_left != 16'd0)};

        n_crc         = r_crc;
        n_bytes_taken = r_bytes_taken;
        n_chunk_left  = r_chunk_left;
        n_active      = r_active;
        n_kind        = gzsbf_pkg::KIND_ERR;
        n_last_idx    = 5'd0;
        n_has_trl     = 1'b0;
        n_bfinal      = bfinal;
        n_chunk       = chunk;
        n_crc_out     = crc_upd ^ gzsbf_pkg::CRC_INIT;

        if (r_in_op == gzsbf_pkg::OP_START) begin
            n_kind        = gzsbf_pkg::KIND_START;
            n_crc         = gzsbf_pkg::CRC_INIT;
            n_bytes_taken = 32'd0;
            n_chunk_left  = chunk;
            n_active      = 1'b1;
            n_last_idx    = 5'(gzsbf_pkg::HEAD_BYTES + gzsbf_pkg::BH_BYTES - 1);
            if (r_total_length == 32'd0) begin
                // Empty member: one empty final block, then a zero trailer.
                n_has_trl  = 1'b1;
                n_active   = 1'b0;
                n_crc_out  = 32'd0;
                n_last_idx = 5'(gzsbf_pkg::MAX_RESULTS - 1);
            end
        end else if (!r_active || (r_bytes_taken >= r_total_length)) begin
            n_kind = gzsbf_pkg::KIND_ERR;
        end else begin
            n_kind        = gzsbf_pkg::KIND_DATA;
            n_crc         = crc_upd;
            n_bytes_taken = bt_inc;
            n_chunk_left  = cl_dec;
            if (bt_inc == r_total_length) begin
                n_has_trl  = 1'b1;
                n_active   = 1'b0;
                n_last_idx = 5'd8;
            end else if (cl_dec == 16'd0) begin
                n_chunk_left = chunk;
                n_last_idx   = 5'(gzsbf_pkg::BH_BYTES);
            end
        end
    end

    // Pick the byte at the current position of the loaded sequence.
    always_comb begin
        off_bh_start  = r_idx - 5'(gzsbf_pkg::HEAD_BYTES);
        off_trl_start = r_idx - 5'(gzsbf_pkg::HEAD_BYTES + gzsbf_pkg::BH_BYTES);
        off_data      = r_idx - 5'd1;
        if (r_kind == gzsbf_pkg::KIND_START) begin
            bh_sel  = off_bh_start[2:0];
            trl_sel = off_trl_start[2:0];
        end else begin
            bh_sel  = off_data[2:0];
            trl_sel = off_data[2:0];
        end

        case (bh_sel)
            3'd0:    bh_b = {7'd0, r_bfinal};
            3'd1:    bh_b = r_chunk[7:0];
            3'd2:    bh_b = r_chunk[15:8];
            3'd3:    bh_b = ~r_chunk[7:0];
            default: bh_b = ~r_chunk[15:8];
        endcase

        case (trl_sel)
            3'd0:    trl_b = r_crc_out[7:0];
            3'd1:    trl_b = r_crc_out[15:8];
            3'd2:    trl_b = r_crc_out[23:16];
            3'd3:    trl_b = r_crc_out[31:24];
            3'd4:    trl_b = r_isize[7:0];
            3'd5:    trl_b = r_isize[15:8];
            3'd6:    trl_b = r_isize[23:16];
            default: trl_b = r_isize[31:24];
        endcase

        use_trl  = 1'b0;
        sel_byte = 8'd0;
        sel_err  = 1'b0;
        unique case (r_kind)
            gzsbf_pkg::KIND_START: begin
                if (r_idx < 5'(gzsbf_pkg::HEAD_BYTES)) begin
                    sel_byte = gzsbf_pkg::head_byte(r_idx[3:0]);
                end else if (r_idx < 5'(gzsbf_pkg::HEAD_BYTES + gzsbf_pkg::BH_BYTES)) begin
                    sel_byte = bh_b;
                end else begin
                    use_trl  = 1'b1;
                    sel_byte = trl_b;
                end
            end
            gzsbf_pkg::KIND_DATA: begin
                if (r_idx == 5'd0) begin
                    sel_byte = r_data;
                end else if (r_has_trl) begin
                    use_trl  = 1'b1;
                    sel_byte = trl_b;
                end else begin
                    sel_byte = bh_b;
                end
            end
            default: begin
                sel_err = 1'b1;
            end
        endcase
        sel_done = use_trl && (trl_sel == 3'd7);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= 32'd0;
            r_crc          <= gzsbf_pkg::CRC_INIT;
            r_bytes_taken  <= 32'd0;
            r_chunk_left   <= 16'd0;
            r_active       <= 1'b0;
            r_in_valid     <= 1'b0;
            r_job_valid    <= 1'b0;
            r_idx          <= 5'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_total_length <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (load) begin
                r_crc         <= n_crc;
                r_bytes_taken <= n_bytes_taken;
                r_chunk_left  <= n_chunk_left;
                r_active      <= n_active;
                r_job_valid   <= 1'b1;
                r_idx         <= 5'd0;
            end else if (job_emit) begin
                if (job_last) begin
                    r_job_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
            if (job_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_op;
            r_in_byte <= i_data_byte;
        end
        if (load) begin
            r_kind     <= n_kind;
            r_last_idx <= n_last_idx;
            r_has_trl  <= n_has_trl;
            r_bfinal   <= n_bfinal;
            r_chunk    <= n_chunk;
            r_crc_out  <= n_crc_out;
            r_isize    <= r_total_length;
            r_data     <= r_in_byte;
        end
        if (job_emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= job_last;
            r_out_done <= sel_done;
            r_out_err  <= sel_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_member_done = r_out_done;
    assign o_error       = r_out_err;

endmodule

@@ rtl/gzsbf_checker.sv @@
// Port-level checks for gzip_stored_block_framer, attached with bind.
// Depends on gzip_stored_block_framer's port list.
module gzsbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_of_run,
    input logic        o_member_done,
    input logic        o_error
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_member_done) && $stable(o_error))
        else $error("result changed while stalled");

    // The end of a member closes the run of its request and is never an error.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_member_done |-> o_last_of_run && !o_error)
        else $error("member end without end of run");

    // An error request produces exactly one zero byte.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last_of_run && o_out_byte == 8'd0 && !o_member_done)
        else $error("malformed error result");

    // Nothing comes out in the cycle right after reset, and requests are welcome.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result valid or request refused after reset");

endmodule

bind gzip_stored_block_framer gzsbf_checker u_gzsbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run),
    .o_member_done (o_member_done),
    .o_error       (o_error)
);
